>>> hdl/shm_pkg.sv
package shm_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 6;
    localparam int BLK_WORDS = 16;
    localparam int BLK_AW    = 4;
    localparam int HASH_WORDS = 8;
    localparam int HASH_AW   = 3;
    localparam int ROUNDS_W  = 6;
    localparam int LEN_W     = 64;

    localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
    localparam logic [FILL_W-1:0] LEN_START = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;

    typedef logic [WORD_W-1:0] t_word;

    // controller states
    typedef enum logic [2:0] {
        S_IN,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_STORE,
        S_OREAD,
        S_OCAP,
        S_OSHOW
    } t_state;

    // round constants
    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial hash value
    localparam t_word IV_TAB [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sig0(input t_word x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word f_ch(input t_word e, input t_word f, input t_word g);
        f_ch = (e & f) ^ (~e & g);
    endfunction

    function automatic t_word f_maj(input t_word a, input t_word b, input t_word c);
        f_maj = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> hdl/sha256_message_hasher_core.sv
// SHA-256 message hasher.
// Input stream: one item per message byte. tdata carries the byte, tuser marks
// that a byte is present, tlast marks the final item of the message. An item
// with tuser low and tlast high ends the message without adding a byte (empty
// message or empty tail); an item with both low is dropped.
// Output stream: eight items per message, digest word 0 (most significant)
// first; tuser carries the word index and tlast flags word 7.
// Data bytes are taken back to back; each full 64-byte block holds the
// input while the chain value is read from its memory into the working
// registers, 64 rounds run at one per cycle, and the sums are added and written back.
// On the last item, padding bytes are fed one per cycle, outside compression,
// through the same byte path (up to 72 bytes, with one or two compressions),
// and each digest word then goes through memory read, capture and present.
// Reset clears the controller and marks every chain entry as holding the
// initial hash value; there is no clearing pass.
// While the receiver stalls, the current digest word holds on the output and
// no input is taken until all eight words are delivered.
module sha256_message_hasher_core
    import shm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_present
    input  logic        i_s_axis_tlast,   // message_end
    // digest stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast    // final_word
);

    t_state                r_state, n_state;
    logic [3:0]            r_cnt, n_cnt;
    logic [ROUNDS_W-1:0]   r_round;
    logic [FILL_W-1:0]     r_fill;
    logic [LEN_W-1:0]      r_bit_count;
    logic [LEN_W-1:0]      r_total;
    logic                  r_pad_active, r_pad_first, r_len_on, r_pad_done;
    logic [2:0]            r_len_cnt;
    logic [HASH_AW-1:0]    r_oidx;
    logic                  r_ovalid;
    t_word                 r_odata;
    logic [HASH_AW-1:0]    r_ouser;
    logic                  r_olast;

    // chain memory with per-entry valid bits (invalid reads as the IV)
    t_word                 r_chain_mem [HASH_WORDS];
    logic [HASH_WORDS-1:0] r_hvalid;
    t_word                 r_ch_q;
    logic                  r_ch_v;
    logic [HASH_AW-1:0]    r_ch_idx;
    t_word                 chain_val;

    // working variables a..h and message schedule window
    t_word                 r_v [HASH_WORDS];
    t_word                 r_w [BLK_WORDS];

    logic                  s_acc;
    logic                  push;
    logic [BYTE_W-1:0]     push_byte;
    logic [BYTE_W-1:0]     pad_byte;
    logic                  pad_zero;
    logic                  ch_rd, ch_we;
    logic [HASH_AW-1:0]    ch_raddr, ch_waddr;
    t_word                 ch_wdata;
    logic [BLK_AW-1:0]     blk_raddr;
    t_word                 blk_word;
    t_word                 wt, t1, t2;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // padding byte: marker, zeros up to byte 56, then the length big-endian
    assign pad_zero = !r_pad_first && !r_len_on && (r_fill != LEN_START);
    assign pad_byte = r_pad_first ? PAD_MARK :
                      (pad_zero ? '0 : r_total[LEN_W-1 -: BYTE_W]);

    // next state and control
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        push            = 1'b0;
        push_byte       = i_s_axis_tdata;
        ch_rd           = 1'b0;
        ch_raddr        = r_cnt[HASH_AW-1:0];
        ch_we           = 1'b0;
        ch_waddr        = r_cnt[HASH_AW-1:0] - 3'd1;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IN: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    push = i_s_axis_tuser;
                    if (i_s_axis_tuser && r_fill == FILL_LAST) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                push      = 1'b1;
                push_byte = pad_byte;
                if (r_fill == FILL_LAST) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end
            end
            S_LOAD: begin
                ch_rd = !r_cnt[3];
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_round == '1) begin
                    n_state = S_STORE;
                    n_cnt   = '0;
                end
            end
            S_STORE: begin
                ch_rd = !r_cnt[3];
                ch_we = (r_cnt != '0);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    if (!r_pad_active) begin
                        n_state = S_IN;
                    end else if (r_pad_done) begin
                        n_state = S_OREAD;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_OREAD: begin
                ch_rd    = 1'b1;
                ch_raddr = r_oidx;
                n_state  = S_OCAP;
            end
            S_OCAP: begin
                n_state = S_OSHOW;
            end
            S_OSHOW: begin
                if (i_m_axis_tready) begin
                    n_state = (r_oidx == '1) ? S_IN : S_OREAD;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IN;
            r_cnt        <= '0;
            r_round      <= '0;
            r_fill       <= '0;
            r_bit_count  <= '0;
            r_pad_active <= 1'b0;
            r_pad_first  <= 1'b0;
            r_len_on     <= 1'b0;
            r_pad_done   <= 1'b0;
            r_len_cnt    <= '0;
            r_oidx       <= '0;
            r_ovalid     <= 1'b0;
            r_hvalid     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_ROUND) begin
                r_round <= r_round + 1'b1;
            end
            if (push) begin
                r_fill <= r_fill + 1'b1;
            end
            // message bookkeeping on input items
            if (s_acc) begin
                if (i_s_axis_tlast) begin
                    r_bit_count  <= '0;
                    r_pad_active <= 1'b1;
                    r_pad_first  <= 1'b1;
                    r_len_on     <= 1'b0;
                    r_pad_done   <= 1'b0;
                    r_len_cnt    <= '0;
                end else if (i_s_axis_tuser) begin
                    r_bit_count <= r_bit_count + LEN_W'(BYTE_W);
                end
            end
            // padding progress
            if (r_state == S_PAD) begin
                if (r_pad_first) begin
                    r_pad_first <= 1'b0;
                end else if (!pad_zero) begin
                    r_len_on  <= 1'b1;
                    r_len_cnt <= r_len_cnt + 1'b1;
                    if (r_len_cnt == '1) begin
                        r_pad_done <= 1'b1;
                    end
                end
            end
            if (ch_we) begin
                r_hvalid[ch_waddr] <= 1'b1;
            end
            // digest output
            if (r_state == S_OCAP) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_OSHOW && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
                r_oidx   <= r_oidx + 1'b1;
                if (r_oidx == '1) begin
                    r_hvalid     <= '0;
                    r_pad_active <= 1'b0;
                end
            end
        end
    end

    // length shift register: loaded at message end, shifted per length byte
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_axis_tlast) begin
            r_total <= r_bit_count + (i_s_axis_tuser ? LEN_W'(BYTE_W) : '0);
        end else if (r_state == S_PAD && !r_pad_first && !pad_zero) begin
            r_total <= {r_total[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
    end

    // chain memory
    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            r_chain_mem[ch_waddr] <= ch_wdata;
        end
        if (ch_rd) begin
            r_ch_q   <= r_chain_mem[ch_raddr];
            r_ch_v   <= r_hvalid[ch_raddr];
            r_ch_idx <= ch_raddr;
        end
    end

    assign chain_val = r_ch_v ? r_ch_q : IV_TAB[r_ch_idx];
    assign ch_wdata  = chain_val + r_v[0];

    // block buffer; during rounds the next word is prefetched
    assign blk_raddr = (r_state == S_ROUND) ? (r_round[BLK_AW-1:0] + 1'b1) : '0;

    shm_block_buf u_buf (
        .i_clk     (i_clk),
        .i_push    (push),
        .i_byte    (push_byte),
        .i_fill    (r_fill),
        .i_rd_addr (blk_raddr),
        .o_rd_word (blk_word)
    );

    // round datapath
    assign wt = (r_round < ROUNDS_W'(BLK_WORDS)) ? blk_word :
                (r_w[0] + small_sig0(r_w[1]) + r_w[9] + small_sig1(r_w[14]));
    assign t1 = r_v[7] + big_sig1(r_v[4]) + f_ch(r_v[4], r_v[5], r_v[6])
              + K_TAB[r_round] + wt;
    assign t2 = big_sig0(r_v[0]) + f_maj(r_v[0], r_v[1], r_v[2]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                // shift chain words in from the top, word 0 ends in a
                if (r_cnt != '0) begin
                    for (int i = 0; i < HASH_WORDS - 1; i++) begin
                        r_v[i] <= r_v[i+1];
                    end
                    r_v[HASH_WORDS-1] <= chain_val;
                end
            end
            S_ROUND: begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                for (int i = 0; i < BLK_WORDS - 1; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[BLK_WORDS-1] <= wt;
            end
            S_STORE: begin
                // rotate so each write sees its own working variable in a
                if (ch_we) begin
                    for (int i = 0; i < HASH_WORDS - 1; i++) begin
                        r_v[i] <= r_v[i+1];
                    end
                    r_v[HASH_WORDS-1] <= r_v[0];
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OCAP) begin
            r_odata <= chain_val;
            r_ouser <= r_oidx;
            r_olast <= (r_oidx == '1);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

>>> hdl/shm_block_buf.sv
// Message block buffer: packs bytes big-endian into words, 16-word memory
module shm_block_buf
    import shm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [FILL_W-1:0] i_fill,
    input  logic [BLK_AW-1:0] i_rd_addr,
    output t_word             o_rd_word
);

    logic [WORD_W-BYTE_W-1:0] r_acc;
    t_word                    r_mem [BLK_WORDS];
    t_word                    r_q;

    // byte gathering and word write on every fourth byte
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_acc <= {r_acc[WORD_W-2*BYTE_W-1:0], i_byte};
            if (i_fill[1:0] == 2'd3) begin
                r_mem[i_fill[FILL_W-1:2]] <= {r_acc, i_byte};
            end
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_word = r_q;

endmodule
